/* sv/rpbm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpbm_pkg: shared types and constants for the refinement path basis matrix
// child matrices, entry and control types used by the level cells
// ----------------------------------------------------------------------------
package rpbm_pkg;

    localparam int DEG_W   = 2;
    localparam int PATH_W  = 16;
    localparam int LEN_W   = 5;
    localparam int ENTRY_W = 64;
    localparam int N_ENT   = 9;

    // supported degree codes
    localparam logic [DEG_W-1:0] DEG_ONE = 2'd1;
    localparam logic [DEG_W-1:0] DEG_TWO = 2'd2;

    typedef logic signed [ENTRY_W-1:0] t_entry;
    typedef t_entry [N_ENT-1:0]        t_mat;   // row-major, m00 in element 0

    typedef struct packed {
        logic              valid;
        logic [DEG_W-1:0]  deg;
        logic [PATH_W-1:0] bits;     // remaining path bits, current level in bit 0
        logic [LEN_W-1:0]  len_rem;  // levels still to apply
    } t_ctl;

    // child matrices scaled by 8, index [set][k][c]
    // set: 0 degree-1 left, 1 degree-1 right, 2 degree-2 left, 3 degree-2 right
    typedef logic signed [4:0] t_coef;
    localparam t_coef COEF [4][3][3] = '{
        '{'{5'sd8, 5'sd4, 5'sd0}, '{5'sd0, 5'sd4, 5'sd0}, '{5'sd0, 5'sd0, 5'sd0}},
        '{'{5'sd4, 5'sd0, 5'sd0}, '{5'sd4, 5'sd8, 5'sd0}, '{5'sd0, 5'sd0, 5'sd0}},
        '{'{5'sd8, 5'sd3, 5'sd0}, '{5'sd0, 5'sd6, 5'sd8}, '{5'sd0, -5'sd1, 5'sd0}},
        '{'{5'sd0, -5'sd1, 5'sd0}, '{5'sd8, 5'sd6, 5'sd0}, '{5'sd0, 5'sd3, 5'sd8}}
    };

    // product by a child coefficient with shifts and adds only
    function automatic t_entry coef_mul(t_entry v, t_coef k);
        t_entry p;
        case (k)
            5'sd8:   p = v <<< 3;
            5'sd6:   p = (v <<< 2) + (v <<< 1);
            5'sd4:   p = v <<< 2;
            5'sd3:   p = (v <<< 1) + v;
            -5'sd1:  p = -v;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

/* sv/rpbm_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpbm_cell: one refinement level
// right-multiplies the incoming matrix by the child matrix, or by 8 past the path
// ----------------------------------------------------------------------------
module rpbm_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  rpbm_pkg::t_ctl i_ctl,
    input  rpbm_pkg::t_mat i_mat,
    output rpbm_pkg::t_ctl o_ctl,
    output rpbm_pkg::t_mat o_mat
);

    rpbm_pkg::t_ctl r_ctl, n_ctl;
    rpbm_pkg::t_mat r_mat, n_mat;
    logic           w_active;
    logic [1:0]     w_set;

    assign w_active = (i_ctl.len_rem != '0);
    assign w_set    = {i_ctl.deg[1], i_ctl.bits[0]};

    always_comb begin
        n_ctl         = i_ctl;
        n_ctl.bits    = i_ctl.bits >> 1;
        n_ctl.len_rem = w_active ? i_ctl.len_rem - 5'd1 : '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (w_active) begin
                    n_mat[r*3+c] =
                        rpbm_pkg::coef_mul(i_mat[r*3],   rpbm_pkg::COEF[w_set][0][c]) +
                        rpbm_pkg::coef_mul(i_mat[r*3+1], rpbm_pkg::COEF[w_set][1][c]) +
                        rpbm_pkg::coef_mul(i_mat[r*3+2], rpbm_pkg::COEF[w_set][2][c]);
                end else begin
                    // past the path: rescale by one level of fraction bits
                    n_mat[r*3+c] = i_mat[r*3+c] <<< 3;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_adv) begin
            r_ctl.valid <= n_ctl.valid;
        end
        if (i_adv) begin
            r_ctl.deg     <= n_ctl.deg;
            r_ctl.bits    <= n_ctl.bits;
            r_ctl.len_rem <= n_ctl.len_rem;
            r_mat         <= n_mat;
        end
    end

    assign o_ctl = r_ctl;
    assign o_mat = r_mat;

endmodule

/* sv/refinement_path_basis_matrix_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refinement_path_basis_matrix_top: basis matrix of a refinement path
// builds the product of child matrices along a path in a chain of level cells
// ----------------------------------------------------------------------------
// usage
//   input word (s_axis): degree, path_bits and path_length. degree 1 gives a
//   2x2 matrix, degree 2 a 3x3 matrix; any other degree flags bad_degree in
//   tuser and returns all-zero entries.
//   output word (m_axis): the nine entries in row order, signed fixed point
//   with 3*MAX_PATH_LEVELS fraction bits, plus bad_degree in tuser.
//   path lengths above MAX_PATH_LEVELS saturate to MAX_PATH_LEVELS.
// timing
//   one cell per path level, MAX_PATH_LEVELS registered cells in a row; a word
//   passes through every cell in order, the last cell giving its result. the
//   chain is fully pipelined: one word per cycle while the receiver does not
//   stall, whatever the path length. cells past the path length only rescale by 8.
// flow control
//   the last cell is the output register. when the receiver stalls with a
//   result pending the whole chain holds and s_axis tready drops; bubbles in
//   the chain are not squeezed out.
// reset
//   synchronous, active low; clears the valid bit of every cell, payload is
//   left as it was.
// ----------------------------------------------------------------------------
module refinement_path_basis_matrix_top #(
    parameter int MAX_PATH_LEVELS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // [1:0] degree, [17:2] path_bits, [22:18] path_length, [23] zero
    input  logic [23:0]  i_s_axis_tdata,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [63:0] m00, [127:64] m01, [191:128] m02, [255:192] m10, [319:256] m11,
    // [383:320] m12, [447:384] m20, [511:448] m21, [575:512] m22
    output logic [575:0] o_m_axis_tdata,
    // [0] bad_degree
    output logic [0:0]   o_m_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready
);

    rpbm_pkg::t_ctl w_ctl [MAX_PATH_LEVELS+1];
    rpbm_pkg::t_mat w_mat [MAX_PATH_LEVELS+1];
    rpbm_pkg::t_ctl w_head_ctl;
    rpbm_pkg::t_mat w_head_mat;
    logic           w_adv;
    logic [1:0]     w_deg;
    logic [1:0]     w_out_deg;

    // chain advances whenever the output register is free or being drained
    assign w_adv           = !w_ctl[MAX_PATH_LEVELS].valid || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    assign w_deg = i_s_axis_tdata[1:0];

    // head of the chain: unpack the word and seed the identity
    always_comb begin
        w_head_ctl.valid   = i_s_axis_tvalid;
        w_head_ctl.deg     = w_deg;
        w_head_ctl.bits    = i_s_axis_tdata[17:2];
        w_head_ctl.len_rem = i_s_axis_tdata[22:18];
        w_head_mat         = '0;
        if (w_deg == rpbm_pkg::DEG_ONE || w_deg == rpbm_pkg::DEG_TWO) begin
            w_head_mat[0] = rpbm_pkg::t_entry'(1);
            w_head_mat[4] = rpbm_pkg::t_entry'(1);
        end
        if (w_deg == rpbm_pkg::DEG_TWO) begin
            w_head_mat[8] = rpbm_pkg::t_entry'(1);
        end
    end

    assign w_ctl[0] = w_head_ctl;
    assign w_mat[0] = w_head_mat;

    // one cell per level; bad degrees start from zero and stay zero
    for (genvar g = 0; g < MAX_PATH_LEVELS; g++) begin : g_cell
        rpbm_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (w_adv),
            .i_ctl  (w_ctl[g]),
            .i_mat  (w_mat[g]),
            .o_ctl  (w_ctl[g+1]),
            .o_mat  (w_mat[g+1])
        );
    end

    assign w_out_deg         = w_ctl[MAX_PATH_LEVELS].deg;
    assign o_m_axis_tvalid   = w_ctl[MAX_PATH_LEVELS].valid;
    assign o_m_axis_tdata    = w_mat[MAX_PATH_LEVELS];
    assign o_m_axis_tuser[0] = !(w_out_deg == rpbm_pkg::DEG_ONE ||
                                 w_out_deg == rpbm_pkg::DEG_TWO);

`ifndef SYNTHESIS
    // an unsupported degree never leaves a nonzero entry
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == '0)
        else $error("bad degree result with nonzero entries");

    // degree one keeps the third row and column clear
    a_deg1_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_out_deg == rpbm_pkg::DEG_ONE |->
        o_m_axis_tdata[575:384] == '0 && o_m_axis_tdata[191:128] == '0 &&
        o_m_axis_tdata[383:320] == '0)
        else $error("degree one result touches third row or column");

    // a stalled result word stays put until it is taken
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output word changed while stalled");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

/* tb/rpbm_matrix_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpbm_matrix_checker: scoreboard for the refinement path basis matrix
// computes each path matrix from the input word and compares the result words
// ----------------------------------------------------------------------------
module rpbm_matrix_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [23:0]  i_s_tdata,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [575:0] i_m_tdata,
    input  logic [0:0]   i_m_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_result_count
);

    localparam int LEVELS = 16;

    typedef struct packed {
        logic         bad;
        logic [575:0] ents;
    } t_matrix_word;

    t_matrix_word matrix_q[$];
    int           fail_cnt = 0;
    int           pend_cnt = 0;
    int           res_cnt  = 0;
    string        fld_name [10] = '{"bad_degree", "m00", "m01", "m02", "m10",
                                    "m11", "m12", "m20", "m21", "m22"};

    assign o_fail_count   = fail_cnt;
    assign o_pending      = pend_cnt;
    assign o_result_count = res_cnt;

    // scaled child coefficient: set 0/1 degree-one left/right, 2/3 degree-two
    function automatic longint child_coef(int set, int k, int c);
        longint tab [9];
        case (set)
            0:       tab = '{8, 4, 0, 0, 4, 0, 0, 0, 0};
            1:       tab = '{4, 0, 0, 4, 8, 0, 0, 0, 0};
            2:       tab = '{8, 3, 0, 0, 6, 8, 0, -1, 0};
            default: tab = '{0, -1, 0, 8, 6, 0, 0, 3, 8};
        endcase
        return tab[k*3 + c];
    endfunction

    function automatic t_matrix_word path_matrix(logic [1:0] deg, logic [15:0] bits,
                                                 logic [4:0] len);
        longint       acc [3][3];
        longint       nxt [3][3];
        longint       s;
        int           n, used, set, sh;
        t_matrix_word res;
        res = '0;
        if (deg != rpbm_pkg::DEG_ONE && deg != rpbm_pkg::DEG_TWO) begin
            res.bad = 1'b1;
            return res;
        end
        used = (int'(len) > LEVELS) ? LEVELS : int'(len);
        n    = int'(deg) + 1;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                acc[r][c] = (r == c && r < n) ? 64'sd1 : 64'sd0;
        for (int lv = 0; lv < used; lv++) begin
            set = (deg == rpbm_pkg::DEG_TWO ? 2 : 0) + int'(bits[lv]);
            for (int r = 0; r < n; r++)
                for (int c = 0; c < n; c++) begin
                    s = 0;
                    for (int k = 0; k < n; k++)
                        s += acc[r][k] * child_coef(set, k, c);
                    nxt[r][c] = s;
                end
            for (int r = 0; r < n; r++)
                for (int c = 0; c < n; c++)
                    acc[r][c] = nxt[r][c];
        end
        // align to the full fraction width
        sh = 3 * (LEVELS - used);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                res.ents[(r*3 + c)*64 +: 64] = acc[r][c] <<< sh;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_matrix_word want;
        logic [63:0]  e, a;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                matrix_q.push_back(path_matrix(i_s_tdata[1:0], i_s_tdata[17:2],
                                               i_s_tdata[22:18]));
            if (i_m_tvalid && i_m_tready) begin
                res_cnt++;
                if (matrix_q.size() == 0) begin
                    if (fail_cnt < 10)
                        $display("unexpected result word at %0t", $realtime);
                    fail_cnt++;
                end else begin
                    want = matrix_q.pop_front();
                    for (int f = 0; f < 10; f++) begin
                        e = (f == 0) ? 64'(want.bad) : want.ents[(f-1)*64 +: 64];
                        a = (f == 0) ? 64'(i_m_tuser[0]) : i_m_tdata[(f-1)*64 +: 64];
                        if (e !== a) begin
                            if (fail_cnt < 10)
                                $display("mismatch on %s at %0t: expected %h got %h",
                                         fld_name[f], $realtime, e, a);
                            fail_cnt++;
                        end
                    end
                end
            end
            pend_cnt = matrix_q.size();
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the refinement path basis matrix block
// directed corner words then random paths, with random gaps and back pressure
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 40;

    // degree codes the block rejects
    localparam logic [1:0] DEG_ZERO  = 2'd0;
    localparam logic [1:0] DEG_THREE = 2'd3;

    logic         i_clk           = 1'b0;
    logic         i_rst_n         = 1'b0;
    logic [23:0]  i_s_axis_tdata  = '0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [575:0] o_m_axis_tdata;
    logic [0:0]   o_m_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;

    int fail_count, pending, result_count;
    int cycles     = 0;
    int words_sent = 0;
    int bad_sent   = 0;
    int long_sent  = 0;
    bit gaps_on    = 1'b1;

    always #5 i_clk = ~i_clk;

    refinement_path_basis_matrix_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready)
    );

    rpbm_matrix_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tdata      (i_s_axis_tdata),
        .i_s_tvalid     (i_s_axis_tvalid),
        .i_s_tready     (o_s_axis_tready),
        .i_m_tdata      (o_m_axis_tdata),
        .i_m_tuser      (o_m_axis_tuser),
        .i_m_tvalid     (o_m_axis_tvalid),
        .i_m_tready     (i_m_axis_tready),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("[refinement_path_basis_matrix_top] ERROR");
            $finish;
        end
    end

    // receiver: stalls with a chance of 11 in a hundred while gaps are on
    always @(posedge i_clk)
        i_m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= 11);

    // offer one path word and hold it until taken; tready is sampled at the
    // falling edge so the handshake decision is free of edge ordering
    task automatic offer_path_word(logic [1:0] deg, logic [15:0] bits, logic [4:0] len);
        logic rdy;
        if (gaps_on && $urandom_range(0, 99) < 11) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        // word layout: [1:0] degree, [17:2] path bits, [22:18] path length
        i_s_axis_tdata  <= {1'b0, len, bits, deg};
        i_s_axis_tvalid <= 1'b1;
        do begin
            @(negedge i_clk);
            rdy = o_s_axis_tready;
            @(posedge i_clk);
        end while (!rdy);
        words_sent++;
        if (deg != rpbm_pkg::DEG_ONE && deg != rpbm_pkg::DEG_TWO)
            bad_sent++;
        if (len > 5'd16)
            long_sent++;
    endtask

    // mostly supported degrees and in-range lengths, some corner lengths
    task automatic random_path_word();
        logic [1:0] deg;
        logic [4:0] len;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            deg = $urandom_range(0, 1) ? DEG_THREE : DEG_ZERO;
        else
            deg = $urandom_range(0, 1) ? rpbm_pkg::DEG_TWO : rpbm_pkg::DEG_ONE;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            len = 5'($urandom_range(17, 31));
        else if (pick < 14)
            len = 5'd16;
        else if (pick < 20)
            len = 5'd0;
        else
            len = 5'($urandom_range(1, 15));
        offer_path_word(deg, 16'($urandom), len);
    endtask

    // hold the sender until every outstanding result has come back
    task automatic wait_results_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unsupported degrees, with and without path content
        offer_path_word(DEG_ZERO, 16'h0000, 5'd0);
        offer_path_word(DEG_THREE, 16'hffff, 5'd31);
        offer_path_word(DEG_ZERO, 16'ha5a5, 5'd16);
        offer_path_word(DEG_THREE, 16'h0001, 5'd1);
        // empty path gives the identity
        offer_path_word(rpbm_pkg::DEG_ONE, 16'hffff, 5'd0);
        offer_path_word(rpbm_pkg::DEG_TWO, 16'hffff, 5'd0);
        // single level, each child
        offer_path_word(rpbm_pkg::DEG_ONE, 16'h0000, 5'd1);
        offer_path_word(rpbm_pkg::DEG_ONE, 16'h0001, 5'd1);
        offer_path_word(rpbm_pkg::DEG_TWO, 16'h0000, 5'd1);
        offer_path_word(rpbm_pkg::DEG_TWO, 16'h0001, 5'd1);
        // full depth, all left, all right, alternating
        offer_path_word(rpbm_pkg::DEG_ONE, 16'h0000, 5'd16);
        offer_path_word(rpbm_pkg::DEG_ONE, 16'hffff, 5'd16);
        offer_path_word(rpbm_pkg::DEG_TWO, 16'h0000, 5'd16);
        offer_path_word(rpbm_pkg::DEG_TWO, 16'hffff, 5'd16);
        offer_path_word(rpbm_pkg::DEG_TWO, 16'haaaa, 5'd16);
        offer_path_word(rpbm_pkg::DEG_TWO, 16'h5555, 5'd16);
        // lengths past the maximum saturate
        offer_path_word(rpbm_pkg::DEG_ONE, 16'hffff, 5'd17);
        offer_path_word(rpbm_pkg::DEG_TWO, 16'hffff, 5'd31);
        offer_path_word(rpbm_pkg::DEG_TWO, 16'h8001, 5'd24);
        // partial lengths ignore the upper path bits
        offer_path_word(rpbm_pkg::DEG_ONE, 16'hfff0, 5'd4);
        offer_path_word(rpbm_pkg::DEG_TWO, 16'h7ffe, 5'd15);

        // a long clean stretch first, then gaps and stalls on both sides
        gaps_on = 1'b0;
        for (int i = 0; i < 1830; i++) begin
            if (i == 500)
                gaps_on = 1'b1;
            if (i == 1000)
                wait_results_drained();
            random_path_word();
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d path words (%0d unsupported degree, %0d over-long paths),",
                 words_sent, bad_sent, long_sent);
        $display("%0d result words checked, %0d mismatches", result_count, fail_count);
        if (fail_count == 0)
            $display("[refinement_path_basis_matrix_top] OK");
        else
            $display("[refinement_path_basis_matrix_top] ERROR");
        $finish;
    end

endmodule
